// ===== design/ledec_pkg.sv =====
// shared types and constants for the leb128 / little-endian field decoder
`default_nettype none

package ledec_pkg;

   // field kind codes, same encoding on the action input and the kind output
   localparam logic [2:0] KIND_U8   = 3'd0;
   localparam logic [2:0] KIND_U16  = 3'd1;
   localparam logic [2:0] KIND_U32  = 3'd2;
   localparam logic [2:0] KIND_SLEB = 3'd3;
   localparam logic [2:0] KIND_ULEB = 3'd4;

   // leb byte layout
   localparam logic [7:0] LEB_PAYLOAD_MASK = 8'h7f;
   localparam int         LEB_CONT_BIT     = 7;
   localparam int         LEB_SIGN_BIT     = 6;
   localparam logic [6:0] LEB_STEP         = 7'd7;
   localparam logic [6:0] LEB_LAST_PARTIAL = 7'd63;

   // byte counter saturation
   localparam logic [3:0] COUNT_MAX = 4'd15;

   // one classified byte passed from the front to the back
   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] kind;
      logic [3:0] index;
      logic       last;
   } entry_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== design/ledec_front.sv =====
// front part: accepts bytes, latches the field kind and marks the last byte
`default_nettype none

module ledec_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire  [7:0]              req_data_byte,
   input  wire  [2:0]              req_action,
   input  ledec_pkg::q_status_type q_status,
   output logic                    push,
   output ledec_pkg::entry_type    push_entry
);
   import ledec_pkg::*;

   logic       in_field_ff, in_field_in;
   logic [2:0] kind_ff, kind_in;
   logic [3:0] count_ff, count_in;

   logic [2:0] cur_kind;
   logic [3:0] cur_index;
   logic [3:0] next_count;
   logic [3:0] need;
   logic       is_leb;
   logic       last;

   // classify the incoming byte
   always_comb begin
      push = req_valid & ~q_status.full;
      if (in_field_ff) begin
         cur_kind  = kind_ff;
         cur_index = count_ff;
      end else begin
         cur_kind  = (req_action <= KIND_ULEB) ? req_action : KIND_U8;
         cur_index = 4'd0;
      end
      next_count = (cur_index == COUNT_MAX) ? COUNT_MAX : cur_index + 4'd1;
      is_leb = (cur_kind == KIND_SLEB) || (cur_kind == KIND_ULEB);
      unique case (cur_kind)
         KIND_U16: need = 4'd2;
         KIND_U32: need = 4'd4;
         default:  need = 4'd1;
      endcase
      if (is_leb) begin
         last = ~req_data_byte[LEB_CONT_BIT];
      end else begin
         last = (next_count >= need);
      end
      push_entry.data_byte = req_data_byte;
      push_entry.kind      = cur_kind;
      push_entry.index     = cur_index;
      push_entry.last      = last;
   end

   // field tracking state
   always_comb begin
      in_field_in = in_field_ff;
      kind_in     = kind_ff;
      count_in    = count_ff;
      if (push) begin
         in_field_in = ~last;
         kind_in     = cur_kind;
         count_in    = next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_field_ff <= 1'b0;
         kind_ff     <= KIND_U8;
         count_ff    <= 4'd0;
      end else begin
         in_field_ff <= in_field_in;
         kind_ff     <= kind_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ledec_queue.sv =====
// two-entry queue between the front and the back
`default_nettype none

module ledec_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  ledec_pkg::entry_type     push_entry,
   input  wire                      pop,
   output ledec_pkg::entry_type     pop_entry,
   output ledec_pkg::q_status_type  q_status
);
   import ledec_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
      q_status.full  = (count_ff == 2'd2);
      q_status.empty = (count_ff == 2'd0);
      pop_entry      = slots_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/ledec_back.sv =====
// back part: merges bytes into the accumulator and holds the result register
`default_nettype none

module ledec_back (
   input  wire                     clock,
   input  wire                     reset,
   input  ledec_pkg::q_status_type q_status,
   input  ledec_pkg::entry_type    pop_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [63:0]             rsp_value,
   output logic [2:0]              rsp_kind,
   output logic [3:0]              rsp_byte_count,
   output logic                    rsp_overflow
);
   import ledec_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [6:0]  bp_ff, bp_in;
   logic        ovf_ff, ovf_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff;
   logic [2:0]  rsp_kind_ff;
   logic [3:0]  rsp_byte_count_ff;
   logic        rsp_overflow_ff;

   logic [63:0] acc_m;
   logic [6:0]  bp_m;
   logic        ovf_m;
   logic [63:0] payload;
   logic [63:0] wide_byte;
   logic        is_leb;
   logic        is_signed;
   logic        sign_ref;
   logic [3:0]  byte_count;

   // take an entry whenever the result register is free or draining
   assign pop = ~q_status.empty & (~rsp_valid_ff | ~rsp_stall);

   // per-byte merge
   always_comb begin
      payload   = {56'd0, pop_entry.data_byte & LEB_PAYLOAD_MASK};
      wide_byte = {56'd0, pop_entry.data_byte};
      is_leb    = (pop_entry.kind == KIND_SLEB) || (pop_entry.kind == KIND_ULEB);
      is_signed = (pop_entry.kind == KIND_SLEB);
      acc_m     = acc_ff;
      bp_m      = bp_ff;
      ovf_m     = ovf_ff;
      sign_ref  = 1'b0;
      if (is_leb) begin
         if (!bp_ff[6]) begin
            acc_m = acc_ff | (payload << bp_ff[5:0]);
            bp_m  = bp_ff + LEB_STEP;
         end
         sign_ref = is_signed & acc_m[63];
         // dropped payload bits above bit 63
         if (bp_ff == LEB_LAST_PARTIAL) begin
            if (pop_entry.data_byte[6:1] != {6{sign_ref}}) begin
               ovf_m = 1'b1;
            end
         end else if (bp_ff[6]) begin
            if (pop_entry.data_byte[6:0] != {7{sign_ref}}) begin
               ovf_m = 1'b1;
            end
         end
         // sign extension on the last signed byte
         if (pop_entry.last && is_signed && pop_entry.data_byte[LEB_SIGN_BIT]
             && !bp_m[6]) begin
            acc_m = acc_m | ({64{1'b1}} << bp_m[5:0]);
         end
      end else begin
         acc_m = acc_ff | (wide_byte << {pop_entry.index[1:0], 3'b000});
      end
      byte_count = (pop_entry.index == COUNT_MAX) ? COUNT_MAX
                                                  : pop_entry.index + 4'd1;
   end

   // field state, cleared once a field completes
   always_comb begin
      acc_in = acc_ff;
      bp_in  = bp_ff;
      ovf_in = ovf_ff;
      if (pop) begin
         if (pop_entry.last) begin
            acc_in = 64'd0;
            bp_in  = 7'd0;
            ovf_in = 1'b0;
         end else begin
            acc_in = acc_m;
            bp_in  = bp_m;
            ovf_in = ovf_m;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (pop && pop_entry.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         bp_ff        <= 7'd0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         bp_ff        <= bp_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && pop_entry.last) begin
         rsp_value_ff      <= acc_m;
         rsp_kind_ff       <= pop_entry.kind;
         rsp_byte_count_ff <= byte_count;
         rsp_overflow_ff   <= is_leb & ovf_m;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_byte_count = rsp_byte_count_ff;
   assign rsp_overflow   = rsp_overflow_ff;

endmodule

`default_nettype wire

// ===== design/leb128_and_le_field_decoder.sv =====
// top level of the leb128 / little-endian field decoder
//
// Input channel req_: one stream byte per transfer, with req_action giving the
// field kind (0 u8, 1 u16, 2 u32, 3 signed leb128, 4 unsigned leb128, other
// codes decode as u8). The kind is taken from the first byte of each field.
// Result channel rsp_: one transfer per completed field with the 64-bit
// value, the kind, the byte count (saturating at 15) and the leb overflow flag.
// Throughput: one byte per cycle while req_stall is low; the back part merges
// each byte into the accumulator with one 64-bit shift and OR.
// rsp_valid rises once the last byte of a field has been written into the queue,
// popped while the result register is free or draining, and merged into the
// result register; a held result or queued bytes ahead of it can delay this.
// A two-entry queue sits between the byte classifier and the merge unit; when
// rsp_stall holds, the result register holds its data, the queue fills and
// req_stall rises once both entries are taken.
// Reset is synchronous: it empties the queue, drops any partial field and
// clears rsp_valid.
`default_nettype none

module leb128_and_le_field_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire  [2:0]  req_action,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_value,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_overflow
);
   import ledec_pkg::*;

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    pop_entry;
   logic         push;
   logic         pop;

   assign req_stall = q_status.full;

   // byte classifier
   ledec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_action    (req_action),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // decoupling queue
   ledec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // merge unit and result register
   ledec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_kind       (rsp_kind),
      .rsp_byte_count (rsp_byte_count),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== design/ledec_checker.sv =====
// port-level checks for the field decoder, bound to the top level
`default_nettype none

module ledec_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [63:0] rsp_value,
   input wire [2:0]  rsp_kind,
   input wire [3:0]  rsp_byte_count,
   input wire        rsp_overflow
);
   import ledec_pkg::*;

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_byte_count))
      else $error("stalled result changed");

   // u8 results are one byte wide
   a_u8: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_U8 |->
         rsp_byte_count == 4'd1 && !rsp_overflow && rsp_value[63:8] == 56'd0)
      else $error("bad u8 result");

   // u16 results are two bytes wide
   a_u16: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_U16 |->
         rsp_byte_count == 4'd2 && !rsp_overflow && rsp_value[63:16] == 48'd0)
      else $error("bad u16 result");

   // u32 results are four bytes wide
   a_u32: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_U32 |->
         rsp_byte_count == 4'd4 && !rsp_overflow && rsp_value[63:32] == 32'd0)
      else $error("bad u32 result");

endmodule

bind leb128_and_le_field_decoder ledec_checker u_ledec_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_value      (rsp_value),
   .rsp_kind       (rsp_kind),
   .rsp_byte_count (rsp_byte_count),
   .rsp_overflow   (rsp_overflow)
);

`default_nettype wire

// ===== tb/sv/leb128_and_le_field_decoder_tb.sv =====
// self-checking testbench for the leb128 / little-endian field decoder
`timescale 1ns / 1ps

module leb128_and_le_field_decoder_tb;
   import ledec_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 500;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 150;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] action;
   } stream_byte_type;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  kind;
      logic [3:0]  byte_count;
      logic        overflow;
   } field_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic [2:0]  req_action    = KIND_U8;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [63:0] rsp_value;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_byte_count;
   logic        rsp_overflow;

   stream_byte_type stream_bytes[$];
   field_type       expected_fields[$];

   // decoder shadow state
   logic [63:0] dec_acc;
   int          dec_bit_pos;
   int          dec_bytes;
   logic [2:0]  dec_kind;
   logic        dec_in_field = 1'b0;
   logic        dec_overflow;

   int              errors        = 0;
   int              cycles        = 0;
   int              bytes_sent    = 0;
   int              total_bytes   = 0;
   int              phase         = 0;
   int              send_idle_pct = 10;
   int              recv_idle_pct = 87;
   logic            req_taken     = 1'b0;
   logic            hold_off      = 1'b0;
   stream_byte_type next_byte;
   field_type       got_field;
   field_type       exp_field;

   leb128_and_le_field_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_action     (req_action),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_kind       (rsp_kind),
      .rsp_byte_count (rsp_byte_count),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic push_byte(input logic [7:0] data, input logic [2:0] action);
      stream_byte_type sb;
      sb.data_byte = data;
      sb.action    = action;
      stream_bytes.push_back(sb);
   endtask

   // one field with random content; leb fields are mostly well formed with varied length
   task automatic add_random_field();
      int          pick;
      int          len;
      int          style;
      logic [2:0]  action;
      logic [6:0]  fill;
      logic [7:0]  data;
      pick = $urandom_range(9);
      if (pick < 2) begin
         action = ($urandom_range(1) == 0) ? KIND_U8 : 3'($urandom_range(5, 7));
      end else if (pick == 2) begin
         action = KIND_U16;
      end else if (pick == 3) begin
         action = KIND_U32;
      end else if (pick < 7) begin
         action = KIND_SLEB;
      end else begin
         action = KIND_ULEB;
      end
      if (action == KIND_SLEB || action == KIND_ULEB) begin
         pick = $urandom_range(9);
         len = (pick < 6) ? $urandom_range(1, 5)
             : (pick < 9) ? $urandom_range(8, 11) : $urandom_range(12, 20);
         style = $urandom_range(3);
         fill = (style == 1) ? 7'h7f : 7'h00;
         if (style == 3) begin
            // noise: raw bytes until one ends the field, the twentieth byte at the latest
            for (int i = 0; i < 20; i++) begin
               data = 8'($urandom_range(255));
               if (i == 19) data[7] = 1'b0;
               push_byte(data, (i == 0) ? action : 3'($urandom_range(7)));
               if (!data[7]) break;
            end
         end else begin
            for (int i = 0; i < len; i++) begin
               data[6:0] = (style == 0 || (i == len - 1 && $urandom_range(1) == 0))
                         ? 7'($urandom_range(127)) : fill;
               data[7] = (i != len - 1);
               push_byte(data, (i == 0) ? action : 3'($urandom_range(7)));
            end
         end
      end else begin
         len = (action == KIND_U16) ? 2 : (action == KIND_U32) ? 4 : 1;
         for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(255)), (i == 0) ? action : 3'($urandom_range(7)));
      end
   endtask

   // advance the shadow decoder by one byte and queue a result when a field closes
   task automatic decode_byte(input logic [7:0] data, input logic [2:0] action);
      int          index;
      int          need;
      int          ndrop;
      logic [6:0]  payload;
      logic [63:0] dropped;
      logic [63:0] mask;
      logic [63:0] sign_fill;
      logic        is_signed;
      logic        done;
      field_type   f;
      done = 1'b0;
      if (!dec_in_field) begin
         dec_acc      = 64'd0;
         dec_bit_pos  = 0;
         dec_bytes    = 0;
         dec_overflow = 1'b0;
         dec_kind     = (action <= KIND_ULEB) ? action : KIND_U8;
         dec_in_field = 1'b1;
      end
      index = dec_bytes;
      if (dec_bytes < 15) dec_bytes++;

      if (dec_kind == KIND_SLEB || dec_kind == KIND_ULEB) begin
         is_signed = (dec_kind == KIND_SLEB);
         payload = data[6:0];
         // merge kept bits, collect the ones that fall past bit 63
         if (dec_bit_pos < 64) begin
            dec_acc |= 64'(payload) << dec_bit_pos;
            if (dec_bit_pos + 7 > 64) begin
               ndrop = dec_bit_pos + 7 - 64;
               dropped = 64'(payload >> (7 - ndrop));
            end else begin
               ndrop = 0;
               dropped = 64'd0;
            end
         end else begin
            ndrop = 7;
            dropped = 64'(payload);
         end
         if (ndrop != 0) begin
            mask = (64'd1 << ndrop) - 64'd1;
            sign_fill = (is_signed && dec_acc[63]) ? mask : 64'd0;
            if ((dropped & mask) != sign_fill) dec_overflow = 1'b1;
         end
         if (dec_bit_pos < 64) dec_bit_pos += 7;
         if (!data[7]) begin
            // sign extension from bit 6 of the last byte
            if (is_signed && data[6] && dec_bit_pos < 64)
               dec_acc |= ~64'd0 << dec_bit_pos;
            done = 1'b1;
         end
      end else begin
         need = (dec_kind == KIND_U16) ? 2 : (dec_kind == KIND_U32) ? 4 : 1;
         dec_acc |= 64'(data) << ((index % 4) * 8);
         done = (dec_bytes >= need);
      end

      if (done) begin
         f.value      = dec_acc;
         f.kind       = dec_kind;
         f.byte_count = 4'(dec_bytes);
         f.overflow   = dec_overflow;
         expected_fields.push_back(f);
         dec_in_field = 1'b0;
      end
   endtask

   // monitor: check result transfers, then feed accepted bytes to the shadow decoder
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_field.value      = rsp_value;
            got_field.kind       = rsp_kind;
            got_field.byte_count = rsp_byte_count;
            got_field.overflow   = rsp_overflow;
            if (expected_fields.size() == 0) begin
               flag_error($sformatf("unexpected result value %h kind %0d count %0d ovf %0b",
                                    rsp_value, rsp_kind, rsp_byte_count, rsp_overflow));
            end else begin
               exp_field = expected_fields.pop_front();
               if (got_field.value !== exp_field.value)
                  flag_error($sformatf("value exp %h got %h",
                                       exp_field.value, got_field.value));
               if (got_field.kind !== exp_field.kind)
                  flag_error($sformatf("kind exp %0d got %0d",
                                       exp_field.kind, got_field.kind));
               if (got_field.byte_count !== exp_field.byte_count)
                  flag_error($sformatf("byte_count exp %0d got %0d",
                                       exp_field.byte_count, got_field.byte_count));
               if (got_field.overflow !== exp_field.overflow)
                  flag_error($sformatf("overflow exp %0b got %0b",
                                       exp_field.overflow, got_field.overflow));
            end
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_action);
      end
   end

   // driver: offer the next byte once the previous transfer is done
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_byte = stream_bytes.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_byte.data_byte;
            req_action    <= next_byte.action;
            bytes_sent++;
            // idle mix: sender light / receiver heavy, then swapped, then none
            if (bytes_sent < total_bytes / 3) begin
               phase = 0; send_idle_pct = 10; recv_idle_pct = 87;
            end else if (bytes_sent < 2 * total_bytes / 3) begin
               phase = 1; send_idle_pct = 87; recv_idle_pct = 10;
            end else begin
               phase = 2; send_idle_pct = 0; recv_idle_pct = 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // long receiver hold-off while the sender keeps streaming
   initial begin
      wait (phase == 2);
      repeat (20) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      // directed: fixed kinds at the extremes, unknown kinds, classic leb values
      push_byte(8'h00, KIND_U8);
      push_byte(8'hff, 3'd7);
      push_byte(8'h34, KIND_U16);
      push_byte(8'h12, 3'd7);
      push_byte(8'hff, KIND_U32);
      push_byte(8'hff, KIND_SLEB);
      push_byte(8'hff, KIND_ULEB);
      push_byte(8'hff, 3'd5);
      push_byte(8'h5a, 3'd5);
      push_byte(8'ha5, 3'd6);
      push_byte(8'h00, KIND_ULEB);
      push_byte(8'he5, KIND_ULEB);
      push_byte(8'h8e, KIND_U8);
      push_byte(8'h26, KIND_U32);
      push_byte(8'h7f, KIND_SLEB);
      push_byte(8'hc0, KIND_SLEB);
      push_byte(8'hbb, KIND_U16);
      push_byte(8'h78, 3'd6);
      push_byte(8'h40, KIND_SLEB);
      push_byte(8'h3f, KIND_SLEB);
      // random fields
      while (stream_bytes.size() < RANDOM_BYTES + 20) add_random_field();
      total_bytes = stream_bytes.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (stream_bytes.size() == 0 && !req_valid);
      wait (expected_fields.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
